/* hdl/dscrs_pkg.sv */
// ----------------------------------------------------------------------------
// dscrs_pkg
// Shared types, codes and constants for the dual-slot calibration record
// selector.
// ----------------------------------------------------------------------------
package dscrs_pkg;

    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [31:0] MAGIC_LEGACY  = 32'h5043_4C31;
    localparam logic [31:0] MAGIC_JOURNAL = 32'h5043_4C32;
    localparam logic [7:0]  FLAG_VALID    = 8'hA5;
    localparam logic [31:0] MARK_COMMIT   = 32'hC04D_17ED;

    localparam int CRC_BITS_LEGACY  = 96;
    localparam int CRC_BITS_JOURNAL = 128;

    localparam logic [15:0] RST_MIN_LIMIT = 16'd0;
    localparam logic [15:0] RST_MAX_LIMIT = 16'd4095;
    localparam logic [15:0] RST_RANGE_MIN = 16'd1;

    // Configuration register indexes
    localparam logic [1:0] CFG_MIN_LIMIT = 2'd0;
    localparam logic [1:0] CFG_MAX_LIMIT = 2'd1;
    localparam logic [1:0] CFG_RANGE_MIN = 2'd2;

    typedef enum logic [1:0] {
        KIND_INVALID = 2'd0,
        KIND_LEGACY  = 2'd1,
        KIND_JOURNAL = 2'd2
    } t_kind;

    typedef struct packed {
        logic        first;
        logic        from_backup;
        logic [31:0] word0;
        logic [31:0] word1;
        logic [31:0] word2;
        logic [31:0] word3;
        logic [31:0] word4;
        logic [31:0] word5;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic        any_valid;
        logic [15:0] best_min;
        logic [15:0] best_max;
        logic [31:0] best_generation;
        logic        best_is_backup;
    } t_out_word;

    typedef struct packed {
        logic [15:0] min_limit;
        logic [15:0] max_limit;
        logic [15:0] range_min;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [31:0] gen;
    } t_class;

    // Reflected CRC-32 over the low nbits of d, LSB first, init and final
    // xor all ones. Only evaluated on constants to build the XOR columns.
    function automatic logic [31:0] crc_raw(logic [127:0] d, int nbits);
        logic [31:0] crc;
        crc = CRC_ALL_ONES;
        for (int i = 0; i < nbits; i++) begin
            crc[0] = crc[0] ^ d[i];
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc ^ CRC_ALL_ONES;
    endfunction

    function automatic logic range_ok(logic [15:0] lo, logic [15:0] hi, t_cfg cfg);
        logic [15:0] span;
        span = hi - lo;
        return (lo >= cfg.min_limit) && (hi <= cfg.max_limit) && (hi > lo) &&
               (span >= cfg.range_min);
    endfunction

endpackage

/* hdl/dscrs_crc.sv */
// ----------------------------------------------------------------------------
// dscrs_crc
// Flat CRC-32 of the page head: 12-byte and 16-byte sums as XOR networks.
// ----------------------------------------------------------------------------
module dscrs_crc (
    input  logic [127:0] i_data,
    output logic [31:0]  o_crc12,
    output logic [31:0]  o_crc16
);

    localparam int NB12 = dscrs_pkg::CRC_BITS_LEGACY;
    localparam int NB16 = dscrs_pkg::CRC_BITS_JOURNAL;
    localparam logic [31:0] BASE12 = dscrs_pkg::crc_raw(128'd0, NB12);
    localparam logic [31:0] BASE16 = dscrs_pkg::crc_raw(128'd0, NB16);

    logic [31:0] terms12 [NB12];
    logic [31:0] terms16 [NB16];

    // The CRC is affine in the data: each set bit xors in a fixed column.
    for (genvar i = 0; i < NB16; i++) begin : g_col
        localparam logic [31:0] COL16 =
            dscrs_pkg::crc_raw(128'd1 << i, NB16) ^ BASE16;
        assign terms16[i] = i_data[i] ? COL16 : 32'd0;
        if (i < NB12) begin : g_col12
            localparam logic [31:0] COL12 =
                dscrs_pkg::crc_raw(128'd1 << i, NB12) ^ BASE12;
            assign terms12[i] = i_data[i] ? COL12 : 32'd0;
        end
    end

    always_comb begin
        o_crc12 = BASE12;
        for (int i = 0; i < NB12; i++) begin
            o_crc12 = o_crc12 ^ terms12[i];
        end
        o_crc16 = BASE16;
        for (int i = 0; i < NB16; i++) begin
            o_crc16 = o_crc16 ^ terms16[i];
        end
    end

endmodule

/* hdl/dscrs_class.sv */
// ----------------------------------------------------------------------------
// dscrs_class
// Layout check: journal first, legacy second, with the range rules.
// ----------------------------------------------------------------------------
module dscrs_class (
    input  dscrs_pkg::t_in_word i_word,
    input  dscrs_pkg::t_cfg     i_cfg,
    output dscrs_pkg::t_class   o_class
);

    logic [31:0] crc12;
    logic [31:0] crc16;
    logic        journal_ok;
    logic        legacy_ok;

    dscrs_crc u_crc (
        .i_data  ({i_word.word3, i_word.word2, i_word.word1, i_word.word0}),
        .o_crc12 (crc12),
        .o_crc16 (crc16)
    );

    assign journal_ok = (i_word.word0 == dscrs_pkg::MAGIC_JOURNAL) &&
                        (i_word.word5 == dscrs_pkg::MARK_COMMIT) &&
                        (crc16 == i_word.word4) &&
                        dscrs_pkg::range_ok(i_word.word2[15:0], i_word.word2[31:16], i_cfg);

    assign legacy_ok = (i_word.word0 == dscrs_pkg::MAGIC_LEGACY) &&
                       (i_word.word2[7:0] == dscrs_pkg::FLAG_VALID) &&
                       (crc12 == i_word.word3) &&
                       dscrs_pkg::range_ok(i_word.word1[15:0], i_word.word1[31:16], i_cfg);

    always_comb begin
        o_class.kind = dscrs_pkg::KIND_INVALID;
        o_class.lo   = 16'd0;
        o_class.hi   = 16'd0;
        o_class.gen  = 32'd0;
        if (journal_ok) begin
            o_class.kind = dscrs_pkg::KIND_JOURNAL;
            o_class.lo   = i_word.word2[15:0];
            o_class.hi   = i_word.word2[31:16];
            o_class.gen  = i_word.word1;
        end else if (legacy_ok) begin
            o_class.kind = dscrs_pkg::KIND_LEGACY;
            o_class.lo   = i_word.word1[15:0];
            o_class.hi   = i_word.word1[31:16];
        end
    end

endmodule

/* hdl/dual_slot_calibration_record_selector_top.sv */
// ----------------------------------------------------------------------------
// dual_slot_calibration_record_selector_top
// Picks the newest valid calibration record from a scan of flash page heads.
// ----------------------------------------------------------------------------
// Each input word is one page head; the block checks it as a journal record,
// then as a legacy record, and keeps the best valid one seen since the last
// word flagged first. One result word comes out per input word: it passes
// through the input register, then the result register, and a new word is
// taken every cycle while the output is not stalled. The cycle time is set
// by the flat 16-byte CRC XOR network feeding the held-record update.
// Configuration writes take effect at once and belong in idle periods.
module dual_slot_calibration_record_selector_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  dscrs_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output dscrs_pkg::t_out_word o_out_word,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    dscrs_pkg::t_cfg      r_cfg;
    logic                 r_s1_valid;
    dscrs_pkg::t_in_word  r_s1_word;
    logic                 r_out_valid;
    dscrs_pkg::t_out_word r_out_word;

    logic                 r_held_valid;
    logic [15:0]          r_held_min;
    logic [15:0]          r_held_max;
    logic [31:0]          r_held_gen;
    logic                 r_held_backup;

    logic                 n_held_valid;
    logic [15:0]          n_held_min;
    logic [15:0]          n_held_max;
    logic [31:0]          n_held_gen;
    logic                 n_held_backup;

    dscrs_pkg::t_class    cls;
    logic                 out_free;
    logic                 s1_adv;
    logic                 in_acc;
    logic [31:0]          gen_diff;
    logic                 take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    dscrs_class u_class (
        .i_word  (r_s1_word),
        .i_cfg   (r_cfg),
        .o_class (cls)
    );

    always_comb begin
        // Start from the held record, or from a cleared one on a new scan.
        n_held_valid  = r_s1_word.first ? 1'b0  : r_held_valid;
        n_held_min    = r_s1_word.first ? 16'd0 : r_held_min;
        n_held_max    = r_s1_word.first ? 16'd0 : r_held_max;
        n_held_gen    = r_s1_word.first ? 32'd0 : r_held_gen;
        n_held_backup = r_s1_word.first ? 1'b0  : r_held_backup;

        // Newer by wrap compare: nonzero difference with the sign bit clear.
        gen_diff = cls.gen - n_held_gen;
        take = (cls.kind != dscrs_pkg::KIND_INVALID) &&
               (!n_held_valid || ((gen_diff != 32'd0) && !gen_diff[31]));

        if (take) begin
            n_held_valid  = 1'b1;
            n_held_min    = cls.lo;
            n_held_max    = cls.hi;
            n_held_gen    = cls.gen;
            n_held_backup = r_s1_word.from_backup;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_limit <= dscrs_pkg::RST_MIN_LIMIT;
            r_cfg.max_limit <= dscrs_pkg::RST_MAX_LIMIT;
            r_cfg.range_min <= dscrs_pkg::RST_RANGE_MIN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dscrs_pkg::CFG_MIN_LIMIT: r_cfg.min_limit <= i_cfg_data;
                dscrs_pkg::CFG_MAX_LIMIT: r_cfg.max_limit <= i_cfg_data;
                dscrs_pkg::CFG_RANGE_MIN: r_cfg.range_min <= i_cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_held_valid  <= 1'b0;
            r_held_min    <= 16'd0;
            r_held_max    <= 16'd0;
            r_held_gen    <= 32'd0;
            r_held_backup <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid   <= 1'b1;
                r_held_valid  <= n_held_valid;
                r_held_min    <= n_held_min;
                r_held_max    <= n_held_max;
                r_held_gen    <= n_held_gen;
                r_held_backup <= n_held_backup;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_word <= i_in_word;
        end
        if (s1_adv) begin
            r_out_word.record_kind     <= cls.kind;
            r_out_word.any_valid       <= n_held_valid;
            r_out_word.best_min        <= n_held_min;
            r_out_word.best_max        <= n_held_max;
            r_out_word.best_generation <= n_held_gen;
            r_out_word.best_is_backup  <= n_held_backup;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
